### src/sbmq_pkg.sv
// Shared types and codes for the shared-buffer multi-queue unit.
package sbmq_pkg;

	localparam int QID_W  = 3;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

endpackage

### src/shared_buffer_multi_queue_unit.sv
// Top level of the shared-buffer multi-queue unit.
//
// Up to QUEUES first-in first-out queues share one store of ENTRIES words. Each
// transfer on the input channel is an enqueue of push_word to queue queue_id or
// a dequeue from it, and each one yields exactly one result transfer with a
// status and, for a successful dequeue, the word removed. In every operation, the
// word store and the link table are read in the cycle the input
// transfer happens and are written back in the next one, and the free-list head
// that the following operation needs is settled only then. No clearing pass is
// needed after reset; entries never used yet are handed out by a fill counter,
// and freed entries are chained into a recycled list through the link table. An
// enqueue is refused with status full when no entry is left, a dequeue from an
// empty queue with status empty, and a queue number at or above QUEUES is
// refused in the same way. A new input transfer is taken while the previous
// result is being taken on the output side.
module shared_buffer_multi_queue_unit
	import sbmq_pkg::*;
#(
	parameter int ENTRIES = 256,
	parameter int QUEUES  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [QID_W-1:0]         queue_id,
	input  logic signed [WORD_W-1:0] push_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [WORD_W-1:0] popped_word
);

	localparam int AW  = $clog2(ENTRIES);
	localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int LW  = AW + 1;

	fsm_t state_q;
	fsm_t state_d;

	logic              kind_s1;
	logic [QID_W-1:0]  qid_s1;
	logic [WORD_W-1:0] word_s1;

	logic [AW-1:0]     head_idx_q [QUEUES];
	logic [QUEUES-1:0] head_vld_q;
	logic [AW-1:0]     tail_q [QUEUES];
	logic [AW-1:0]     rec_head_q;
	logic              rec_vld_q;
	logic [AW:0]       fill_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [WORD_W-1:0] popped_q;

	logic              accept;
	logic              exec;
	logic [QIW-1:0]    qidx_in;
	logic [QIW-1:0]    qidx_s1;
	logic [AW-1:0]     rd_addr;
	logic              q_ok;
	logic              head_v;
	logic [AW-1:0]     head_i;
	logic [AW-1:0]     tail_i;
	logic              free_ok;
	logic              enq_go;
	logic              deq_go;
	logic [AW-1:0]     slot;

	logic              link_we;
	logic [AW-1:0]     link_waddr;
	logic [LW-1:0]     link_wdata;
	logic [LW-1:0]     link_rdata;
	logic [WORD_W-1:0] data_rdata;

	sbmq_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(WORD_W)
	) u_data_ram (
		.clk   (clk),
		.we    (enq_go),
		.waddr (slot),
		.wdata (word_s1),
		.raddr (rd_addr),
		.rdata (data_rdata)
	);

	sbmq_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(LW)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		exec     = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = !(out_valid_q && !out_ready);
				if (in_valid && in_ready) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				exec    = 1'b1;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign accept  = in_valid && in_ready;
	assign qidx_in = QIW'(queue_id);
	assign qidx_s1 = QIW'(qid_s1);
	assign rd_addr = (kind == KIND_DEQ) ? head_idx_q[qidx_in] : rec_head_q;

	assign q_ok    = 32'(qid_s1) < 32'(QUEUES);
	assign head_v  = head_vld_q[qidx_s1];
	assign head_i  = head_idx_q[qidx_s1];
	assign tail_i  = tail_q[qidx_s1];
	assign free_ok = rec_vld_q || (fill_q < LW'(ENTRIES));
	assign enq_go  = exec && (kind_s1 == KIND_ENQ) && q_ok && free_ok;
	assign deq_go  = exec && (kind_s1 == KIND_DEQ) && q_ok && head_v;
	assign slot    = rec_vld_q ? rec_head_q : fill_q[AW-1:0];

	always_comb begin
		link_we    = 1'b0;
		link_waddr = tail_i;
		link_wdata = {1'b0, slot};
		if (enq_go && head_v) begin
			link_we = 1'b1;
		end else if (deq_go) begin
			link_we    = 1'b1;
			link_waddr = head_i;
			link_wdata = {!rec_vld_q, rec_head_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			qid_s1  <= queue_id;
			word_s1 <= push_word;
		end
		if (enq_go) begin
			tail_q[qidx_s1] <= slot;
			if (!head_v) begin
				head_idx_q[qidx_s1] <= slot;
			end
			if (rec_vld_q) begin
				rec_head_q <= link_rdata[AW-1:0];
			end
		end
		if (deq_go) begin
			head_idx_q[qidx_s1] <= link_rdata[AW-1:0];
			rec_head_q          <= head_i;
		end
		if (exec) begin
			status_q <= (kind_s1 == KIND_ENQ) ? (enq_go ? STAT_DONE : STAT_FULL)
				: (deq_go ? STAT_DONE : STAT_EMPTY);
			popped_q <= deq_go ? data_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= '0;
			rec_vld_q   <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (enq_go) begin
				head_vld_q[qidx_s1] <= 1'b1;
				if (rec_vld_q) begin
					rec_vld_q <= !link_rdata[AW];
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (deq_go) begin
				rec_vld_q <= 1'b1;
				if (head_i == tail_i) begin
					head_vld_q[qidx_s1] <= 1'b0;
				end
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign popped_word = popped_q;

endmodule

### src/sbmq_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module sbmq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
